// ----- rtl/priority_inheritance_lock_unit_macros.svh -----
// assertion macros for the priority inheritance lock unit
// used by the rtl files that carry concurrent checks; needs clk_i and rst_ni in scope
`ifndef PRIORITY_INHERITANCE_LOCK_UNIT_MACROS_SVH
`define PRIORITY_INHERITANCE_LOCK_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PIU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PIU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define PIU_ASSERT(label, prop, msg)
`define PIU_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/piu_pkg.sv -----
// shared widths, codes and control structs of the priority inheritance lock unit
// no dependencies
`default_nettype none

package piu_pkg;

  localparam int unsigned TASK_W   = 12;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned STATUS_W = 3;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STS_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STS_QUEUED   = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] STS_HANDOVER = 3'd4;

  // control from the lock sequencer to the waiter table
  typedef struct packed {
    logic              insert;
    logic              release_top;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] task_prio;
  } tbl_cmd_t;

  // status from the waiter table
  typedef struct packed {
    logic              full;
    logic              done;
    logic              top_valid;
    logic [TASK_W-1:0] top_task;
    logic [PRIO_W-1:0] top_prio;
  } tbl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/piu_if.sv -----
// request and response channel interfaces of the priority inheritance lock unit
// depends on piu_pkg
`default_nettype none

interface piu_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [piu_pkg::TASK_W-1:0]  task_id;
  logic [piu_pkg::PRIO_W-1:0]  task_prio;

  modport source (output valid, output op, output task_id, output task_prio, input ready);
  modport sink   (input valid, input op, input task_id, input task_prio, output ready);
endinterface

interface piu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [piu_pkg::STATUS_W-1:0]  status;
  logic [piu_pkg::TASK_W-1:0]    owner_task;
  logic                          owner_valid;
  logic [piu_pkg::PRIO_W-1:0]    owner_eff_prio;
  logic                          prio_changed;
  logic [piu_pkg::TASK_W-1:0]    restored_task;
  logic [piu_pkg::PRIO_W-1:0]    restored_prio;

  modport source (output valid, output status, output owner_task, output owner_valid,
                  output owner_eff_prio, output prio_changed, output restored_task,
                  output restored_prio, input ready);
  modport sink   (input valid, input status, input owner_task, input owner_valid,
                  input owner_eff_prio, input prio_changed, input restored_task,
                  input restored_prio, output ready);
endinterface

`default_nettype wire

// ----- rtl/priority_inheritance_lock_unit.sv -----
// priority inheritance lock unit: lock sequencer, holder registers and result register
// depends on piu_pkg, piu_if, piu_table
//
//   channel  dir  payload                                       handshake
//   req_i    in   op, task_id, task_prio                        valid/ready
//   rsp_o    out  status, owner_task, owner_valid,              valid/ready
//                 owner_eff_prio, prio_changed, restored_task,
//                 restored_prio
//
// one request at a time: an acquire or a release without waiters goes from ST_EXEC to ST_RESP,
// then to the output register; a release that hands over first scans the waiter ram in ST_SCAN.
// the handover scan reads one ram entry per cycle, fixing ages and finding the next top.
// reset clears slot valid bits at once, no clearing pass; ram contents are not reset.
// a new request is taken while the previous result waits in the output register.
`default_nettype none

module priority_inheritance_lock_unit #(
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  piu_req_if.sink   req_i,
  piu_rsp_if.source rsp_o
);

  localparam int unsigned TW = piu_pkg::TASK_W;
  localparam int unsigned PW = piu_pkg::PRIO_W;
  localparam int unsigned SW = piu_pkg::STATUS_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic          op_q, op_d;
  logic [TW-1:0] tid_q, tid_d;
  logic [PW-1:0] prio_q, prio_d;

  logic          held_q, held_d;
  logic [TW-1:0] hid_q, hid_d;
  logic [PW-1:0] base_q, base_d;
  logic [PW-1:0] eff_q, eff_d;

  logic [SW-1:0] res_status_q, res_status_d;
  logic          res_chg_q, res_chg_d;
  logic [TW-1:0] res_rtask_q, res_rtask_d;
  logic [PW-1:0] res_rprio_q, res_rprio_d;

  logic          out_valid_q, out_valid_d;
  logic [SW-1:0] out_status_q;
  logic [TW-1:0] out_owner_q;
  logic          out_ovalid_q;
  logic [PW-1:0] out_eff_q;
  logic          out_chg_q;
  logic [TW-1:0] out_rtask_q;
  logic [PW-1:0] out_rprio_q;

  logic              accept;
  logic              out_load;
  piu_pkg::tbl_cmd_t tbl_cmd;
  piu_pkg::tbl_sts_t tbl_sts;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_load    = (state_q == ST_RESP) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    tid_d        = tid_q;
    prio_d       = prio_q;
    held_d       = held_q;
    hid_d        = hid_q;
    base_d       = base_q;
    eff_d        = eff_q;
    res_status_d = res_status_q;
    res_chg_d    = res_chg_q;
    res_rtask_d  = res_rtask_q;
    res_rprio_d  = res_rprio_q;
    tbl_cmd      = '0;
    tbl_cmd.task_id   = tid_q;
    tbl_cmd.task_prio = prio_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d    = req_i.op;
          tid_d   = req_i.task_id;
          prio_d  = req_i.task_prio;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_chg_d   = 1'b0;
        res_rtask_d = '0;
        res_rprio_d = '0;
        state_d     = ST_RESP;
        if (op_q == piu_pkg::OP_ACQUIRE) begin
          if (!held_q) begin
            held_d       = 1'b1;
            hid_d        = tid_q;
            base_d       = prio_q;
            eff_d        = prio_q;
            res_status_d = piu_pkg::STS_GRANTED;
          end else if (tbl_sts.full) begin
            res_status_d = piu_pkg::STS_FULL;
          end else begin
            tbl_cmd.insert = 1'b1;
            res_status_d   = piu_pkg::STS_QUEUED;
            // inherit the waiter's priority
            if (eff_q > prio_q) begin
              eff_d     = prio_q;
              res_chg_d = 1'b1;
            end
          end
        end else begin
          res_status_d = piu_pkg::STS_RELEASED;
          if (held_q) begin
            res_rtask_d = hid_q;
            res_rprio_d = base_q;
            res_chg_d   = (eff_q != base_q);
            if (!tbl_sts.top_valid) begin
              held_d = 1'b0;
              hid_d  = '0;
              base_d = '0;
              eff_d  = '0;
            end else begin
              // hand the lock straight to the top waiter
              tbl_cmd.release_top = 1'b1;
              hid_d        = tbl_sts.top_task;
              base_d       = tbl_sts.top_prio;
              eff_d        = tbl_sts.top_prio;
              res_status_d = piu_pkg::STS_HANDOVER;
              state_d      = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (tbl_sts.done) begin
          // new owner inherits from the waiters left behind
          if (tbl_sts.top_valid && (tbl_sts.top_prio < eff_q)) begin
            eff_d     = tbl_sts.top_prio;
            res_chg_d = 1'b1;
          end
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= 1'b0;
      hid_q       <= '0;
      base_q      <= '0;
      eff_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      hid_q       <= hid_d;
      base_q      <= base_d;
      eff_q       <= eff_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tid_q        <= tid_d;
    prio_q       <= prio_d;
    res_status_q <= res_status_d;
    res_chg_q    <= res_chg_d;
    res_rtask_q  <= res_rtask_d;
    res_rprio_q  <= res_rprio_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_owner_q  <= hid_q;
      out_ovalid_q <= held_q;
      out_eff_q    <= eff_q;
      out_chg_q    <= res_chg_q;
      out_rtask_q  <= res_rtask_q;
      out_rprio_q  <= res_rprio_q;
    end
  end

  piu_table #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (tbl_cmd),
    .sts_o  (tbl_sts)
  );

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.owner_task     = out_owner_q;
  assign rsp_o.owner_valid    = out_ovalid_q;
  assign rsp_o.owner_eff_prio = out_eff_q;
  assign rsp_o.prio_changed   = out_chg_q;
  assign rsp_o.restored_task  = out_rtask_q;
  assign rsp_o.restored_prio  = out_rprio_q;

`include "priority_inheritance_lock_unit_macros.svh"

  `PIU_ASSERT(a_no_waiters_when_free, !held_q |-> !tbl_sts.top_valid, "waiters queued on a free lock")
  `PIU_ASSERT(a_eff_not_below_base, held_q |-> (eff_q <= base_q), "owner effective priority less urgent than base")
  `PIU_ASSERT_NEXT(a_scan_ends_in_resp, (state_q == ST_SCAN) && tbl_sts.done, state_q == ST_RESP, "handover scan did not finish")

endmodule

`default_nettype wire

// ----- rtl/piu_ram.sv -----
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module piu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/piu_table.sv -----
// waiter table: slot valid bits, entry ram, cached top waiter and the release scan
// depends on piu_pkg and piu_ram
`default_nettype none

module piu_table #(
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  piu_pkg::tbl_cmd_t cmd_i,
  output piu_pkg::tbl_sts_t sts_o
);

  localparam int unsigned IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned CW = $clog2(MAX_WAITERS + 1);
  localparam int unsigned TW = piu_pkg::TASK_W;
  localparam int unsigned PW = piu_pkg::PRIO_W;
  localparam int unsigned EW = TW + PW + CW;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_WAITERS - 1);

  logic [MAX_WAITERS-1:0] used_q, used_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   top_v_q, top_v_d;
  logic [IW-1:0]          top_idx_q, top_idx_d;
  logic [TW-1:0]          top_task_q, top_task_d;
  logic [PW-1:0]          top_prio_q, top_prio_d;
  logic [CW-1:0]          top_age_q, top_age_d;
  logic                   scan_q, scan_d;
  logic [IW-1:0]          rd_idx_q, rd_idx_d;
  logic                   rd_v_q, rd_v_d;
  logic                   rd_last_q, rd_last_d;
  logic [IW-1:0]          dt_idx_q, dt_idx_d;
  logic                   done_q, done_d;
  logic [CW-1:0]          gone_age_q, gone_age_d;
  logic                   best_v_q, best_v_d;
  logic [IW-1:0]          best_idx_q, best_idx_d;
  logic [TW-1:0]          best_task_q, best_task_d;
  logic [PW-1:0]          best_prio_q, best_prio_d;
  logic [CW-1:0]          best_age_q, best_age_d;

  logic [IW-1:0] free_idx;
  logic          full;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [TW-1:0] r_task;
  logic [PW-1:0] r_prio;
  logic [CW-1:0] r_age;
  logic [CW-1:0] new_age;
  logic          cur_used;
  logic          take;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = MAX_WAITERS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign full = &used_q;

  assign r_task  = ram_rdata[EW-1 -: TW];
  assign r_prio  = ram_rdata[CW +: PW];
  assign r_age   = ram_rdata[CW-1:0];
  // ranks above the one that left close the gap
  assign new_age = (r_age > gone_age_q) ? (r_age - CW'(1)) : r_age;
  assign cur_used = used_q[dt_idx_q];
  assign take = rd_v_q && cur_used &&
                (!best_v_q || (r_prio < best_prio_q) ||
                 ((r_prio == best_prio_q) && (new_age < best_age_q)));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dt_idx_q;
    ram_wdata = {r_task, r_prio, new_age};
    if (cmd_i.insert) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx;
      ram_wdata = {cmd_i.task_id, cmd_i.task_prio, count_q};
    end else if (rd_v_q && cur_used) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    used_d      = used_q;
    count_d     = count_q;
    top_v_d     = top_v_q;
    top_idx_d   = top_idx_q;
    top_task_d  = top_task_q;
    top_prio_d  = top_prio_q;
    top_age_d   = top_age_q;
    scan_d      = scan_q;
    rd_idx_d    = rd_idx_q;
    rd_v_d      = scan_q;
    rd_last_d   = scan_q && (rd_idx_q == LAST_IDX);
    dt_idx_d    = rd_idx_q;
    done_d      = rd_v_q && rd_last_q;
    gone_age_d  = gone_age_q;
    best_v_d    = best_v_q;
    best_idx_d  = best_idx_q;
    best_task_d = best_task_q;
    best_prio_d = best_prio_q;
    best_age_d  = best_age_q;

    if (cmd_i.insert) begin
      used_d[free_idx] = 1'b1;
      count_d          = count_q + CW'(1);
      // a newcomer is younger than every waiter, so it wins only on priority
      if (!top_v_q || (cmd_i.task_prio < top_prio_q)) begin
        top_v_d    = 1'b1;
        top_idx_d  = free_idx;
        top_task_d = cmd_i.task_id;
        top_prio_d = cmd_i.task_prio;
        top_age_d  = count_q;
      end
    end

    if (cmd_i.release_top) begin
      used_d[top_idx_q] = 1'b0;
      count_d           = count_q - CW'(1);
      gone_age_d        = top_age_q;
      scan_d            = 1'b1;
      rd_idx_d          = '0;
      best_v_d          = 1'b0;
    end

    if (scan_q) begin
      if (rd_idx_q == LAST_IDX) begin
        scan_d = 1'b0;
      end else begin
        rd_idx_d = rd_idx_q + IW'(1);
      end
    end

    if (take) begin
      best_v_d    = 1'b1;
      best_idx_d  = dt_idx_q;
      best_task_d = r_task;
      best_prio_d = r_prio;
      best_age_d  = new_age;
    end

    if (rd_v_q && rd_last_q) begin
      top_v_d    = best_v_d;
      top_idx_d  = best_idx_d;
      top_task_d = best_task_d;
      top_prio_d = best_prio_d;
      top_age_d  = best_age_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      count_q   <= '0;
      top_v_q   <= 1'b0;
      scan_q    <= 1'b0;
      rd_idx_q  <= '0;
      rd_v_q    <= 1'b0;
      rd_last_q <= 1'b0;
      done_q    <= 1'b0;
      best_v_q  <= 1'b0;
    end else begin
      used_q    <= used_d;
      count_q   <= count_d;
      top_v_q   <= top_v_d;
      scan_q    <= scan_d;
      rd_idx_q  <= rd_idx_d;
      rd_v_q    <= rd_v_d;
      rd_last_q <= rd_last_d;
      done_q    <= done_d;
      best_v_q  <= best_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_idx_q   <= top_idx_d;
    top_task_q  <= top_task_d;
    top_prio_q  <= top_prio_d;
    top_age_q   <= top_age_d;
    dt_idx_q    <= dt_idx_d;
    gone_age_q  <= gone_age_d;
    best_idx_q  <= best_idx_d;
    best_task_q <= best_task_d;
    best_prio_q <= best_prio_d;
    best_age_q  <= best_age_d;
  end

  piu_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WAITERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (scan_q),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign sts_o.full      = full;
  assign sts_o.done      = done_q;
  assign sts_o.top_valid = top_v_q;
  assign sts_o.top_task  = top_task_q;
  assign sts_o.top_prio  = top_prio_q;

`include "priority_inheritance_lock_unit_macros.svh"

  `PIU_ASSERT(a_count_matches_used, count_q == CW'($countones(used_q)), "waiter count out of step with slot bits")
  `PIU_ASSERT(a_no_insert_in_scan, (scan_q || rd_v_q) |-> !cmd_i.insert, "insert during release scan")
  `PIU_ASSERT(a_insert_not_full, cmd_i.insert |-> !full, "insert into full table")

endmodule

`default_nettype wire

// ----- tb/sv/priority_inheritance_lock_unit_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the priority inheritance lock unit: directed and random
// requests, a lock state predictor and an in-order result check; needs piu_pkg and piu_if

module priority_inheritance_lock_unit_tb;

  localparam int WAITERS     = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = WAITERS + 10;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  typedef struct packed {
    logic [piu_pkg::STATUS_W-1:0] status;
    logic [piu_pkg::TASK_W-1:0]   owner_task;
    logic                         owner_valid;
    logic [piu_pkg::PRIO_W-1:0]   owner_eff_prio;
    logic                         prio_changed;
    logic [piu_pkg::TASK_W-1:0]   restored_task;
    logic [piu_pkg::PRIO_W-1:0]   restored_prio;
  } lock_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  piu_req_if req_if ();
  piu_rsp_if rsp_if ();

  priority_inheritance_lock_unit #(
    .MAX_WAITERS(WAITERS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predicted lock state
  logic                       pl_held;
  logic [piu_pkg::TASK_W-1:0] pl_owner;
  logic [piu_pkg::PRIO_W-1:0] pl_base;
  logic [piu_pkg::PRIO_W-1:0] pl_eff;
  logic                       wt_used [WAITERS];
  logic [piu_pkg::TASK_W-1:0] wt_task [WAITERS];
  logic [piu_pkg::PRIO_W-1:0] wt_prio [WAITERS];
  logic [7:0]                 wt_age  [WAITERS];
  logic [7:0]                 wt_count;

  lock_rsp_t expected_rsp_q [$];
  int        mismatch_count = 0;

  // sender and receiver pacing
  int       tx_max_gap  = 0;
  int       burst_left  = 0;
  rx_mode_e rx_mode     = RX_ALWAYS;
  logic     rx_hold_arm = 1'b0;
  int       rx_hold_left = 0;
  logic [7:0] rx_pattern = 8'b1011_0110;

  function automatic int find_top_waiter();
    int best;
    best = -1;
    for (int i = 0; i < WAITERS; i++) begin
      if (wt_used[i] && (best < 0 || wt_prio[i] < wt_prio[best] ||
          (wt_prio[i] == wt_prio[best] && wt_age[i] < wt_age[best])))
        best = i;
    end
    return best;
  endfunction

  function automatic lock_rsp_t predict_lock(logic op, logic [piu_pkg::TASK_W-1:0] id,
                                             logic [piu_pkg::PRIO_W-1:0] prio);
    lock_rsp_t r;
    int        slot;
    int        top;
    logic [7:0] gone_age;
    r = '0;
    if (op == piu_pkg::OP_ACQUIRE) begin
      if (!pl_held) begin
        pl_held  = 1'b1;
        pl_owner = id;
        pl_base  = prio;
        pl_eff   = prio;
        r.status = piu_pkg::STS_GRANTED;
      end else begin
        slot = -1;
        for (int i = 0; i < WAITERS; i++)
          if (!wt_used[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.status = piu_pkg::STS_FULL;
        end else begin
          wt_used[slot] = 1'b1;
          wt_task[slot] = id;
          wt_prio[slot] = prio;
          wt_age[slot]  = wt_count;
          wt_count      = wt_count + 8'd1;
          if (pl_eff > prio) begin
            pl_eff = prio;
            r.prio_changed = 1'b1;
          end
          r.status = piu_pkg::STS_QUEUED;
        end
      end
    end else if (!pl_held) begin
      r.status = piu_pkg::STS_RELEASED;
    end else begin
      // any release acts for the holder
      r.restored_task = pl_owner;
      r.restored_prio = pl_base;
      if (pl_eff != pl_base) r.prio_changed = 1'b1;
      top = find_top_waiter();
      if (top < 0) begin
        pl_held  = 1'b0;
        pl_owner = '0;
        pl_base  = '0;
        pl_eff   = '0;
        r.status = piu_pkg::STS_RELEASED;
      end else begin
        gone_age = wt_age[top];
        pl_owner = wt_task[top];
        pl_base  = wt_prio[top];
        pl_eff   = wt_prio[top];
        wt_used[top] = 1'b0;
        for (int i = 0; i < WAITERS; i++)
          if (wt_used[i] && wt_age[i] > gone_age) wt_age[i] = wt_age[i] - 8'd1;
        if (wt_count > 0) wt_count = wt_count - 8'd1;
        top = find_top_waiter();
        if (top >= 0 && wt_prio[top] < pl_eff) begin
          pl_eff = wt_prio[top];
          r.prio_changed = 1'b1;
        end
        r.status = piu_pkg::STS_HANDOVER;
      end
    end
    r.owner_valid    = pl_held;
    r.owner_task     = pl_held ? pl_owner : '0;
    r.owner_eff_prio = pl_held ? pl_eff : '0;
    return r;
  endfunction

  // one request; valid stays high afterwards unless the next call opens a gap
  task automatic send_req(input logic op, input logic [piu_pkg::TASK_W-1:0] id,
                          input logic [piu_pkg::PRIO_W-1:0] prio);
    int gap;
    if (tx_max_gap > 0 && burst_left == 0) begin
      gap = $urandom_range(1, tx_max_gap);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    req_if.valid     <= 1'b1;
    req_if.op        <= op;
    req_if.task_id   <= id;
    req_if.task_prio <= prio;
    do @(posedge clk_i); while (!req_if.ready);
    expected_rsp_q.push_back(predict_lock(op, id, prio));
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic compare_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // receiver: stall pattern per mode, plus a long hold counted here
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rx_hold_arm) begin
        rx_hold_arm  = 1'b0;
        rx_hold_left = HOLD_CYCLES;
      end
      rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  rsp_if.ready <= 1'b1;
          RX_RANDOM:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
          default:    rsp_if.ready <= rx_pattern[0];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    lock_rsp_t exp_rsp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: result with no request pending, expected none actual status %0d",
                 $time, rsp_if.status);
        mismatch_count++;
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        compare_field("status", exp_rsp.status, rsp_if.status);
        compare_field("owner_task", exp_rsp.owner_task, rsp_if.owner_task);
        compare_field("owner_valid", exp_rsp.owner_valid, rsp_if.owner_valid);
        compare_field("owner_eff_prio", exp_rsp.owner_eff_prio, rsp_if.owner_eff_prio);
        compare_field("prio_changed", exp_rsp.prio_changed, rsp_if.prio_changed);
        compare_field("restored_task", exp_rsp.restored_task, rsp_if.restored_task);
        compare_field("restored_prio", exp_rsp.restored_prio, rsp_if.restored_prio);
      end
    end
  end

  // boost, fifo among equal priorities, owner re-acquire, foreign release, free release
  task automatic test_directed_cases();
    tx_max_gap = 0;
    rx_mode    = RX_ALWAYS;
    send_req(piu_pkg::OP_RELEASE, 12'h005, 8'd9);
    send_req(piu_pkg::OP_ACQUIRE, 12'hFFF, 8'd200);
    send_req(piu_pkg::OP_ACQUIRE, 12'h000, 8'd255);
    send_req(piu_pkg::OP_ACQUIRE, 12'h0A5, 8'd50);
    send_req(piu_pkg::OP_ACQUIRE, 12'h5A0, 8'd50);
    send_req(piu_pkg::OP_ACQUIRE, 12'hFFF, 8'd0);
    send_req(piu_pkg::OP_RELEASE, 12'h123, 8'd7);
    send_req(piu_pkg::OP_RELEASE, 12'hFFF, 8'd0);
    send_req(piu_pkg::OP_RELEASE, 12'h0A5, 8'd50);
    send_req(piu_pkg::OP_RELEASE, 12'h5A0, 8'd50);
    send_req(piu_pkg::OP_RELEASE, 12'h000, 8'd255);
    send_req(piu_pkg::OP_RELEASE, 12'h000, 8'd0);
    wait_results_drained();
  endtask

  // fill every waiter slot, then overflow with an urgent request that must not boost
  task automatic test_table_full();
    while (pl_held) send_req(piu_pkg::OP_RELEASE, 12'(($urandom_range(0, 4095))), 8'd0);
    send_req(piu_pkg::OP_ACQUIRE, 12'(($urandom_range(0, 4095))), 8'd255);
    for (int i = 0; i < WAITERS; i++)
      send_req(piu_pkg::OP_ACQUIRE, 12'(($urandom_range(0, 4095))),
               8'(($urandom_range(1, 254))));
    send_req(piu_pkg::OP_ACQUIRE, 12'h7FF, 8'd0);
    send_req(piu_pkg::OP_ACQUIRE, 12'h800, 8'd255);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int n_items, input int acq_pct,
                                     input rx_mode_e mode, input int max_gap);
    logic                       op;
    logic [piu_pkg::TASK_W-1:0] id;
    logic [piu_pkg::PRIO_W-1:0] prio;
    int                         sel;
    int                         pick;
    rx_mode    = mode;
    tx_max_gap = max_gap;
    burst_left = 0;
    for (int n = 0; n < n_items; n++) begin
      if (!pl_held) begin
        op = ($urandom_range(0, 9) == 0) ? piu_pkg::OP_RELEASE : piu_pkg::OP_ACQUIRE;
      end else begin
        op = ($urandom_range(0, 99) < acq_pct) ? piu_pkg::OP_ACQUIRE : piu_pkg::OP_RELEASE;
      end
      id  = 12'($urandom_range(0, 4095));
      sel = $urandom_range(0, 9);
      if (sel == 0 && pl_held) begin
        id = pl_owner;
      end else if (sel == 1 && wt_count > 0) begin
        // reuse the id of a task already waiting
        pick = $urandom_range(0, WAITERS - 1);
        for (int i = 0; i < WAITERS; i++)
          if (wt_used[(pick + i) % WAITERS]) id = wt_task[(pick + i) % WAITERS];
      end
      sel = $urandom_range(0, 9);
      if (sel < 4) prio = 8'($urandom_range(0, 3));
      else if (sel < 8) prio = 8'($urandom_range(0, 139));
      else prio = 8'($urandom_range(0, 255));
      send_req(op, id, prio);
    end
    wait_results_drained();
  endtask

  // receiver holds off while requests keep coming, then the sender waits for all results
  task automatic test_output_backpressure();
    tx_max_gap = 0;
    rx_mode    = RX_RANDOM;
    rx_hold_arm = 1'b1;
    for (int n = 0; n < 40; n++)
      send_req(($urandom_range(0, 1) == 0) ? piu_pkg::OP_ACQUIRE : piu_pkg::OP_RELEASE,
               12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
    wait_results_drained();
  endtask

  initial begin
    req_if.valid     = 1'b0;
    req_if.op        = piu_pkg::OP_ACQUIRE;
    req_if.task_id   = '0;
    req_if.task_prio = '0;
    rsp_if.ready     = 1'b0;
    pl_held  = 1'b0;
    pl_owner = '0;
    pl_base  = '0;
    pl_eff   = '0;
    wt_count = '0;
    for (int i = 0; i < WAITERS; i++) begin
      wt_used[i] = 1'b0;
      wt_task[i] = '0;
      wt_prio[i] = '0;
      wt_age[i]  = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_table_full();
    test_random_traffic(400, 60, RX_ALWAYS, 0);
    test_random_traffic(400, 75, RX_RANDOM, 6);
    test_output_backpressure();
    test_random_traffic(400, 45, RX_PATTERN, 3);
    test_random_traffic(400, 55, RX_RANDOM, 8);

    wait_results_drained();
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/piu_pkg.sv
rtl/piu_if.sv
rtl/piu_ram.sv
rtl/piu_table.sv
rtl/priority_inheritance_lock_unit.sv
tb/sv/priority_inheritance_lock_unit_tb.sv
